### rtl/cslex_pkg.sv
// Shared types, codes and character-class helpers for the C subset lexer.
package cslex_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 255;
  localparam int LEN_W             = 8;
  localparam int POS_W             = 32;
  localparam int CHAR_W            = 8;
  localparam int KIND_W            = 3;
  localparam int PREFIX_DEPTH      = 6;
  localparam int NKEYWORDS         = 11;
  localparam int KW_W              = PREFIX_DEPTH * CHAR_W;
  localparam int QDEPTH            = 4;

  localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ARITH   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REL     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_KEYWORD = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OTHER   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd6;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // Keyword text with the first character in the low byte, so strings read reversed.
  localparam logic [KW_W-1:0] KW_TEXT [NKEYWORDS] = '{
    KW_W'("tni"), KW_W'("taolf"), KW_W'("elbuod"), KW_W'("niam"),
    KW_W'("loob"), KW_W'("nruter"), KW_W'("rahc"), KW_W'("tcurts"),
    KW_W'("diov"), KW_W'("fi"), KW_W'("esle")
  };
  localparam logic [LEN_W-1:0] KW_LEN [NKEYWORDS] = '{
    8'd3, 8'd5, 8'd6, 8'd4, 8'd4, 8'd6, 8'd4, 8'd6, 8'd4, 8'd2, 8'd4
  };

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [POS_W-1:0]  start_offset;
    logic [LEN_W-1:0]  token_length;
    logic              last_of_run;
  } out_item_t;

  // Up to two results caused by one input transfer, item0 first.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } res_pair_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_rel(input logic [CHAR_W-1:0] c);
    return (c == ">") || (c == "<") || (c == "=") || (c == "!");
  endfunction

  function automatic logic is_arith(input logic [CHAR_W-1:0] c);
    return (c == "+") || (c == "*") || (c == "/") || (c == "-");
  endfunction

  // Prefix bytes past the length are zero, so a full-width compare is exact.
  function automatic logic kw_match(input logic [LEN_W-1:0] len,
                                    input logic [KW_W-1:0] pfx);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NKEYWORDS; i++) begin
      if (len == KW_LEN[i] && pfx == KW_TEXT[i]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

### rtl/c_subset_lexer_unit.sv
// Top level of the streaming C subset lexer.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------------
//  input   | in  | in_valid / in_ready | in_data  : mode, ch (one byte per transfer)
//  result  | out | out_valid/out_ready | out_data : token_kind, start_offset,
//          |     |                     |            token_length, last_of_run
//
// One character per cycle while in_ready is high: the scanner updates its state in
// the cycle of the transfer and writes its results into a four-entry result buffer,
// read one per cycle while out_ready is high. Ending a token and emitting another
// pushes two results; in_ready drops when the buffer holds more than two results.
// Synchronous reset clears scanner state and empties the buffer; no clearing pass.
module c_subset_lexer_unit #(
  parameter int MAX_TOKEN_LEN = cslex_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cslex_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cslex_pkg::out_item_t out_data
);
  import cslex_pkg::*;

  logic      fire;
  res_pair_t res;

  assign fire = in_valid && in_ready;

  cslex_scan #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .in_data(in_data),
    .res    (res)
  );

  cslex_rbuf u_rbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .res      (res),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

### rtl/cslex_scan.sv
// Scanner state and per-character token logic; yields up to two results per transfer.
module cslex_scan #(
  parameter int MAX_TOKEN_LEN = cslex_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  cslex_pkg::in_item_t  in_data,
  output cslex_pkg::res_pair_t res
);
  import cslex_pkg::*;

  localparam int LEN_CAP_I = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);
  localparam int PIDX_W = $clog2(PREFIX_DEPTH);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_IDENT  = 2'd1;
  localparam logic [1:0] PH_NUMBER = 2'd2;
  localparam logic [1:0] PH_REL    = 2'd3;

  logic [1:0]                          phase, phase_next;
  logic [CHAR_W-1:0]                   rel_char, rel_char_next;
  logic [PREFIX_DEPTH-1:0][CHAR_W-1:0] prefix, prefix_next;
  logic [LEN_W-1:0]                    cur_len, cur_len_next;
  logic [POS_W-1:0]                    cur_start, cur_start_next;
  logic [POS_W-1:0]                    byte_pos, byte_pos_next;

  logic              fin_v, sec_v, do_start;
  out_item_t         fin_rec, sec_rec;
  logic [CHAR_W-1:0] c;

  always_comb begin
    c              = in_data.ch;
    phase_next     = phase;
    rel_char_next  = rel_char;
    prefix_next    = prefix;
    cur_len_next   = cur_len;
    cur_start_next = cur_start;
    byte_pos_next  = byte_pos;
    fin_v          = 1'b0;
    sec_v          = 1'b0;
    do_start       = 1'b0;
    sec_rec        = '0;

    fin_rec              = '0;
    fin_rec.start_offset = cur_start;
    case (phase)
      PH_IDENT: begin
        fin_rec.token_kind   = kw_match(cur_len, prefix) ? KIND_KEYWORD : KIND_IDENT;
        fin_rec.token_length = cur_len;
      end
      PH_NUMBER: begin
        fin_rec.token_kind   = KIND_NUMBER;
        fin_rec.token_length = cur_len;
      end
      PH_REL: begin
        fin_rec.token_kind   = (rel_char == "=") ? KIND_OTHER : KIND_REL;
        fin_rec.token_length = LEN_W'(1);
      end
      default: begin
        fin_rec.token_kind   = KIND_OTHER;
        fin_rec.token_length = '0;
      end
    endcase

    if (in_data.mode == MODE_END) begin
      fin_v                = (phase != PH_IDLE);
      sec_v                = 1'b1;
      sec_rec.token_kind   = KIND_END;
      sec_rec.start_offset = byte_pos;
      sec_rec.token_length = '0;
      phase_next           = PH_IDLE;
    end else begin
      byte_pos_next = byte_pos + POS_W'(1);
      case (phase)
        PH_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (cur_len < LEN_W'(PREFIX_DEPTH)) prefix_next[cur_len[PIDX_W-1:0]] = c;
            if (cur_len < LEN_CAP) cur_len_next = cur_len + LEN_W'(1);
          end else begin
            fin_v    = 1'b1;
            do_start = 1'b1;
          end
        end
        PH_NUMBER: begin
          if (is_digit(c) || c == ".") begin
            if (cur_len < LEN_CAP) cur_len_next = cur_len + LEN_W'(1);
          end else begin
            fin_v    = 1'b1;
            do_start = 1'b1;
          end
        end
        PH_REL: begin
          if (c == "=") begin
            sec_v                = 1'b1;
            sec_rec.token_kind   = KIND_REL;
            sec_rec.start_offset = cur_start;
            sec_rec.token_length = LEN_W'(2);
            phase_next           = PH_IDLE;
          end else begin
            fin_v    = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      if (do_start) begin
        phase_next = PH_IDLE;
        if (is_space(c)) begin
          phase_next = PH_IDLE;
        end else if (is_alpha(c)) begin
          phase_next     = PH_IDENT;
          prefix_next    = '0;
          prefix_next[0] = c;
          cur_start_next = byte_pos;
          cur_len_next   = LEN_W'(1);
        end else if (is_digit(c)) begin
          phase_next     = PH_NUMBER;
          cur_start_next = byte_pos;
          cur_len_next   = LEN_W'(1);
        end else if (is_rel(c)) begin
          phase_next     = PH_REL;
          rel_char_next  = c;
          cur_start_next = byte_pos;
          cur_len_next   = LEN_W'(1);
        end else begin
          // NUL and every byte outside the classes above land here, as arith or else as other
          sec_v                = 1'b1;
          sec_rec.token_kind   = is_arith(c) ? KIND_ARITH : KIND_OTHER;
          sec_rec.start_offset = byte_pos;
          sec_rec.token_length = LEN_W'(1);
        end
      end
    end

    res = '0;
    if (fin_v) begin
      res.cnt               = sec_v ? 2'd2 : 2'd1;
      res.item0             = fin_rec;
      res.item0.last_of_run = !sec_v;
      res.item1             = sec_rec;
      res.item1.last_of_run = 1'b1;
    end else if (sec_v) begin
      res.cnt               = 2'd1;
      res.item0             = sec_rec;
      res.item0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      rel_char  <= '0;
      prefix    <= '0;
      cur_len   <= '0;
      cur_start <= '0;
      byte_pos  <= '0;
    end else if (fire) begin
      phase     <= phase_next;
      rel_char  <= rel_char_next;
      prefix    <= prefix_next;
      cur_len   <= cur_len_next;
      cur_start <= cur_start_next;
      byte_pos  <= byte_pos_next;
    end
  end

  a_end_emits_end: assert property (@(posedge clk) disable iff (rst)
    (fire && in_data.mode == MODE_END) |->
      ((res.cnt == 2'd1 && res.item0.token_kind == KIND_END) ||
       (res.cnt == 2'd2 && res.item1.token_kind == KIND_END)))
    else $error("end transfer without end token");

  a_len_capped: assert property (@(posedge clk) disable iff (rst)
    cur_len <= LEN_CAP)
    else $error("token length above cap");

  a_pos_steps: assert property (@(posedge clk) disable iff (rst)
    (fire && in_data.mode == MODE_CHAR) |=> byte_pos == $past(byte_pos) + POS_W'(1))
    else $error("byte position did not advance");

endmodule

### rtl/cslex_rbuf.sv
// Result buffer: takes up to two results per cycle, delivers one per cycle while out_ready is high.
module cslex_rbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cslex_pkg::res_pair_t res,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cslex_pkg::out_item_t out_data
);
  import cslex_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  out_item_t          q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   n_in;
  logic               pop;

  assign n_in      = push ? CNT_W'(res.cnt) : '0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = q[rd_ptr];
  // Room for a worst-case pair is judged on the registered count only.
  assign room      = (count <= CNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (n_in != '0) q[wr_ptr] <= res.item0;
    if (n_in == CNT_W'(2)) q[wr_ptr + PTR_W'(1)] <= res.item1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_in);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + n_in - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QDEPTH))
    else $error("result buffer overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("push without room");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule
